// ===== hdl/sfla_pkg.sv =====
// Package for the segregated free-list allocator: field widths, types and the control store.
package sfla_pkg;

    localparam int ADDR_W  = 14;
    localparam int BYTES_W = 18;
    localparam int WORDS_W = 15;

    localparam logic [WORDS_W-1:0] WORDS_MAX = 15'h7FFF;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic {
        ST_OK  = 1'b0,
        ST_OOM = 1'b1
    } t_status;

    typedef struct packed {
        logic              nil;
        logic [ADDR_W-1:0] addr;
    } t_link;

    localparam t_link LINK_NIL = '{nil: 1'b1, addr: '0};

    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_DEC   = 4'd1,
        S_STAKE = 4'd2,
        S_POP   = 4'd3,
        S_OTAKE = 4'd4,
        S_WALK  = 4'd5,
        S_EMIT  = 4'd6,
        S_FREE  = 4'd7,
        S_BUMP  = 4'd8
    } t_step;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HEAD_RD,
        OP_TAKE,
        OP_POP,
        OP_WALK,
        OP_FREE,
        OP_BUMP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_JUMP,
        C_WAIT_IN,
        C_DISPATCH,
        C_HEAD_NIL,
        C_WALK,
        C_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step pc);
        t_ctrl c;
        unique case (pc)
            S_IDLE:  c = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: S_DEC};
            S_DEC:   c = '{op: OP_HEAD_RD, cond: C_DISPATCH, target: S_FREE};
            S_STAKE: c = '{op: OP_TAKE,    cond: C_HEAD_NIL, target: S_BUMP};
            S_POP:   c = '{op: OP_POP,     cond: C_JUMP,     target: S_EMIT};
            S_OTAKE: c = '{op: OP_TAKE,    cond: C_HEAD_NIL, target: S_BUMP};
            S_WALK:  c = '{op: OP_WALK,    cond: C_WALK,     target: S_BUMP};
            S_EMIT:  c = '{op: OP_EMIT,    cond: C_WAIT_OUT, target: S_IDLE};
            S_FREE:  c = '{op: OP_FREE,    cond: C_JUMP,     target: S_EMIT};
            S_BUMP:  c = '{op: OP_BUMP,    cond: C_JUMP,     target: S_EMIT};
            default: c = '{op: OP_NONE,    cond: C_JUMP,     target: S_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/sfla_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module sfla_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/segregated_free_list_allocator_top.sv =====
// Top level of the segregated free-list allocator with its microcoded sequencer and datapath.
//
//  channel   direction  handshake          word
//  request   in         i_valid / o_ready  i_req_type, i_request_bytes, i_block_address
//  result    out        o_valid / i_ready  o_granted_address, o_status, o_from_free_list
//
// A free steps through decode, free and emit; a small-class allocate through decode, take,
// pop or bump, and emit. A large allocate walks the overflow list for an exact size, falling
// back to the bump pointer when that list is empty or the walk ends unmatched; the walk is
// paced by the block link and size RAM read ports, one node per cycle. The next word can be
// accepted in the cycle after the result register is loaded.
// Reset empties every class list through per-class valid flip-flops; there is no clearing pass.
// A finished result waits in the emit step while the output register is still occupied.
module segregated_free_list_allocator_top
    import sfla_pkg::*;
#(
    parameter int HEAP_WORDS   = 16384,
    parameter int SIZE_CLASSES = 32,
    parameter int WORD_BYTES   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [ADDR_W-1:0]  i_block_address,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ADDR_W-1:0]  o_granted_address,
    output logic               o_status,
    output logic               o_from_free_list
);

    localparam int AW     = $clog2(HEAP_WORDS);
    localparam int CW     = $clog2(SIZE_CLASSES);
    localparam int QW     = BYTES_W + 1;
    localparam int SUM_W  = ((AW > WORDS_W) ? AW : WORDS_W) + 1;
    localparam int CMP_W  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int STEP_W = $clog2(HEAP_WORDS + 1);
    localparam int LINK_W = $bits(t_link);

    t_step r_pc, n_pc;
    t_ctrl ctrl;

    t_req                r_kind, n_kind;
    logic [WORDS_W-1:0]  r_words, n_words;
    logic [CW-1:0]       r_cls, n_cls;
    logic                r_small, n_small;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_in_heap, n_in_heap;
    t_link               r_cur, n_cur;
    t_link               r_prev, n_prev;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [AW-1:0]       r_bump, n_bump;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    t_status             r_res_status, n_res_status;
    logic                r_res_reused, n_res_reused;
    logic [SIZE_CLASSES-1:0] r_head_valid, n_head_valid;
    logic                r_o_valid, n_o_valid;
    logic [ADDR_W-1:0]   r_o_addr, n_o_addr;
    t_status             r_o_status, n_o_status;
    logic                r_o_reused, n_o_reused;

    logic [QW-1:0]       round_bytes;
    logic [QW-1:0]       quot;
    logic [WORDS_W-1:0]  in_words;
    logic                in_small;
    logic                in_acc;
    logic                out_free;
    logic                walk_end;
    logic                walk_hit;
    logic [SUM_W-1:0]    bump_sum;
    logic                bump_oom;

    logic                head_we;
    logic [LINK_W-1:0]   head_wdata;
    logic                head_re;
    logic [LINK_W-1:0]   head_rdata;
    t_link               head_eff;

    logic                link_we;
    logic [AW-1:0]       link_waddr;
    logic [LINK_W-1:0]   link_wdata;
    logic                link_re;
    logic [AW-1:0]       link_raddr;
    logic [LINK_W-1:0]   link_rdata;
    t_link               link_rd;

    logic                words_we;
    logic [WORDS_W-1:0]  words_rdata;

    sfla_ram #(.WIDTH(LINK_W), .DEPTH(SIZE_CLASSES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_cls),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (r_cls),
        .o_rdata (head_rdata)
    );

    sfla_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_WORDS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sfla_ram #(.WIDTH(WORDS_W), .DEPTH(HEAP_WORDS)) u_words_ram (
        .i_clk   (i_clk),
        .i_we    (words_we),
        .i_waddr (AW'(r_addr)),
        .i_wdata (r_words),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (words_rdata)
    );

    assign round_bytes = QW'(i_request_bytes) + QW'(WORD_BYTES - 1);
    assign quot        = round_bytes / QW'(WORD_BYTES);

    always_comb begin
        if (quot == '0) begin
            in_words = WORDS_W'(1);
        end else if (quot > QW'(WORDS_MAX)) begin
            in_words = WORDS_MAX;
        end else begin
            in_words = WORDS_W'(quot);
        end
    end

    assign in_small = in_words < WORDS_W'(SIZE_CLASSES);

    assign o_ready  = (r_pc == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    assign head_eff = r_head_valid[r_cls] ? t_link'(head_rdata) : LINK_NIL;
    assign link_rd  = t_link'(link_rdata);

    assign walk_end = r_cur.nil || (r_steps == STEP_W'(HEAP_WORDS));
    assign walk_hit = (words_rdata == r_words);
    assign bump_sum = SUM_W'(r_bump) + SUM_W'(r_words);
    assign bump_oom = bump_sum >= SUM_W'(HEAP_WORDS);

    always_comb begin
        ctrl = ucode(r_pc);

        n_kind       = r_kind;
        n_words      = r_words;
        n_cls        = r_cls;
        n_small      = r_small;
        n_addr       = r_addr;
        n_in_heap    = r_in_heap;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_bump       = r_bump;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_reused = r_res_reused;
        n_head_valid = r_head_valid;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_addr     = r_o_addr;
        n_o_status   = r_o_status;
        n_o_reused   = r_o_reused;

        head_we    = 1'b0;
        head_wdata = link_rdata;
        head_re    = 1'b0;
        link_we    = 1'b0;
        link_waddr = AW'(r_addr);
        link_wdata = link_rdata;
        link_re    = 1'b0;
        link_raddr = AW'(link_rd.addr);
        words_we   = 1'b0;

        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                if (in_acc) begin
                    n_kind       = t_req'(i_req_type);
                    n_words      = in_words;
                    n_small      = in_small;
                    n_cls        = in_small ? CW'(in_words) : '0;
                    n_addr       = i_block_address;
                    n_in_heap    = CMP_W'(i_block_address) < CMP_W'(HEAP_WORDS);
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    n_res_reused = 1'b0;
                end
            end
            OP_HEAD_RD: begin
                head_re = 1'b1;
            end
            OP_TAKE: begin
                n_cur      = head_eff;
                n_prev     = LINK_NIL;
                n_steps    = '0;
                link_re    = 1'b1;
                link_raddr = AW'(head_eff.addr);
            end
            OP_POP: begin
                head_we                 = 1'b1;
                head_wdata              = link_rdata;
                n_head_valid[r_cls]     = 1'b1;
                n_res_addr              = r_cur.addr;
                n_res_reused            = 1'b1;
            end
            OP_WALK: begin
                if (!walk_end) begin
                    if (walk_hit) begin
                        if (r_prev.nil) begin
                            head_we             = 1'b1;
                            head_wdata          = link_rdata;
                            n_head_valid[r_cls] = 1'b1;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = AW'(r_prev.addr);
                            link_wdata = link_rdata;
                        end
                        n_res_addr   = r_cur.addr;
                        n_res_reused = 1'b1;
                    end else begin
                        n_prev     = r_cur;
                        n_cur      = link_rd;
                        n_steps    = r_steps + STEP_W'(1);
                        link_re    = 1'b1;
                        link_raddr = AW'(link_rd.addr);
                    end
                end
            end
            OP_FREE: begin
                if (r_in_heap) begin
                    link_we             = 1'b1;
                    link_waddr          = AW'(r_addr);
                    link_wdata          = head_eff;
                    words_we            = 1'b1;
                    head_we             = 1'b1;
                    head_wdata          = t_link'{nil: 1'b0, addr: r_addr};
                    n_head_valid[r_cls] = 1'b1;
                end
            end
            OP_BUMP: begin
                if (bump_oom) begin
                    n_res_status = ST_OOM;
                end else begin
                    n_res_addr = ADDR_W'(r_bump);
                    n_bump     = AW'(bump_sum);
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_status = r_res_status;
                    n_o_reused = r_res_reused;
                end
            end
            default: begin
            end
        endcase

        unique case (ctrl.cond)
            C_JUMP: begin
                n_pc = ctrl.target;
            end
            C_WAIT_IN: begin
                n_pc = in_acc ? ctrl.target : r_pc;
            end
            C_DISPATCH: begin
                if (r_kind == REQ_FREE) begin
                    n_pc = ctrl.target;
                end else if (!r_small) begin
                    n_pc = S_OTAKE;
                end else begin
                    n_pc = t_step'(r_pc + 4'd1);
                end
            end
            C_HEAD_NIL: begin
                n_pc = head_eff.nil ? ctrl.target : t_step'(r_pc + 4'd1);
            end
            C_WALK: begin
                if (walk_end) begin
                    n_pc = ctrl.target;
                end else if (walk_hit) begin
                    n_pc = t_step'(r_pc + 4'd1);
                end else begin
                    n_pc = r_pc;
                end
            end
            C_WAIT_OUT: begin
                n_pc = out_free ? ctrl.target : r_pc;
            end
            default: begin
                n_pc = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_o_valid    <= 1'b0;
            r_bump       <= '0;
        end else begin
            r_head_valid <= n_head_valid;
            r_o_valid    <= n_o_valid;
            r_bump       <= n_bump;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_words      <= n_words;
        r_cls        <= n_cls;
        r_small      <= n_small;
        r_addr       <= n_addr;
        r_in_heap    <= n_in_heap;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_reused <= n_res_reused;
        r_o_addr     <= n_o_addr;
        r_o_status   <= n_o_status;
        r_o_reused   <= n_o_reused;
    end

    assign o_valid           = r_o_valid;
    assign o_granted_address = r_o_addr;
    assign o_status          = r_o_status;
    assign o_from_free_list  = r_o_reused;

`ifndef SYNTH
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_pc == S_DEC))
        else $error("accepted word did not move the sequencer to decode");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OOM) |-> (o_granted_address == '0 && !o_from_free_list))
        else $error("out-of-memory result carries an address or reuse flag");

    a_bump_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((AW+1)'(r_bump) < (AW+1)'(HEAP_WORDS)))
        else $error("bump pointer left the heap");

    a_free_no_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT && r_kind == REQ_FREE) |-> !r_res_reused)
        else $error("free request reports a reused block");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT && (!r_o_valid || i_ready)) |=> (r_o_valid && r_pc == S_IDLE))
        else $error("emit step did not load the output register");
`endif

endmodule

// ===== verif/sfla_checker.sv =====
// Checker for the segregated free-list allocator: predicts every result word and compares it.
`timescale 1ns / 100ps

module sfla_checker
    import sfla_pkg::*;
#(
    parameter int HEAP_WORDS   = 16384,
    parameter int SIZE_CLASSES = 32,
    parameter int WORD_BYTES   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic               i_req_type,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [ADDR_W-1:0]  i_block_address,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [ADDR_W-1:0]  i_granted_address,
    input  logic               i_status,
    input  logic               i_from_free_list,
    output int                 o_failures
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic              reused;
    } t_grant;

    t_link              heads[SIZE_CLASSES];
    t_link              links[HEAP_WORDS];
    logic [WORDS_W-1:0] sizes[HEAP_WORDS];
    int unsigned        bump;
    t_grant             grants_due[$];
    t_grant             due;
    int                 mismatches = 0;

    function automatic logic [WORDS_W-1:0] word_count(input logic [BYTES_W-1:0] nbytes);
        int unsigned w;
        w = (int'(nbytes) + WORD_BYTES - 1) / WORD_BYTES;
        if (w == 0) begin
            w = 1;
        end
        if (w > WORDS_MAX) begin
            w = WORDS_MAX;
        end
        return w[WORDS_W-1:0];
    endfunction

    // Walks the shared list of large blocks for an exact size and unlinks the first match.
    function automatic t_link overflow_take(input logic [WORDS_W-1:0] words);
        t_link prev;
        t_link cur;
        int    steps;
        prev  = LINK_NIL;
        cur   = heads[0];
        steps = 0;
        while (!cur.nil && int'(cur.addr) < HEAP_WORDS && steps < HEAP_WORDS) begin
            if (sizes[cur.addr] == words) begin
                if (prev.nil) begin
                    heads[0] = links[cur.addr];
                end else begin
                    links[prev.addr] = links[cur.addr];
                end
                return cur;
            end
            prev = cur;
            cur  = links[cur.addr];
            steps++;
        end
        return LINK_NIL;
    endfunction

    function automatic t_grant predict_grant(input t_req op,
                                             input logic [BYTES_W-1:0] nbytes,
                                             input logic [ADDR_W-1:0] blk);
        t_grant             g;
        logic [WORDS_W-1:0] words;
        t_link              hit;
        int                 cls;
        g     = '{addr: '0, status: ST_OK, reused: 1'b0};
        words = word_count(nbytes);
        if (op == REQ_FREE) begin
            if (int'(blk) < HEAP_WORDS) begin
                cls         = (words < SIZE_CLASSES) ? int'(words) : 0;
                sizes[blk]  = words;
                links[blk]  = heads[cls];
                heads[cls]  = '{nil: 1'b0, addr: blk};
            end
        end else begin
            hit = LINK_NIL;
            if (words < SIZE_CLASSES) begin
                if (!heads[words].nil && int'(heads[words].addr) < HEAP_WORDS) begin
                    hit          = heads[words];
                    heads[words] = links[hit.addr];
                end
            end else begin
                hit = overflow_take(words);
            end
            if (!hit.nil) begin
                g.addr   = hit.addr;
                g.reused = 1'b1;
            end else if (bump + words >= HEAP_WORDS) begin
                g.status = ST_OOM;
            end else begin
                g.addr = bump[ADDR_W-1:0];
                bump   = bump + words;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (heads[i]) heads[i] = LINK_NIL;
            foreach (links[i]) links[i] = '0;
            foreach (sizes[i]) sizes[i] = '0;
            bump = 0;
            grants_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (grants_due.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatches++;
                end else begin
                    due = grants_due.pop_front();
                    if (i_granted_address !== due.addr) begin
                        $error("granted_address: expected %0d, got %0d",
                               due.addr, i_granted_address);
                        mismatches++;
                    end
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        mismatches++;
                    end
                    if (i_from_free_list !== due.reused) begin
                        $error("from_free_list: expected %0d, got %0d",
                               due.reused, i_from_free_list);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                grants_due.push_back(predict_grant(t_req'(i_req_type), i_request_bytes,
                                                   i_block_address));
            end
        end
        o_failures <= mismatches + grants_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the segregated free-list allocator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb;
    import sfla_pkg::*;

    localparam int HEAP_WORDS     = 16384;
    localparam int SIZE_CLASSES   = 32;
    localparam int WORD_BYTES     = 8;
    localparam int RANDOM_WORDS   = 1250;
    localparam int CALM_FROM      = 1100;
    localparam int SQUEEZE_AT     = 300;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        t_req               kind;
        logic [BYTES_W-1:0] nbytes;
    } t_sent;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    t_req               req_kind;
    logic [BYTES_W-1:0] req_bytes;
    logic [ADDR_W-1:0]  req_addr;
    logic               res_valid;
    logic               res_ready;
    logic [ADDR_W-1:0]  res_addr;
    logic               res_status;
    logic               res_reused;
    int                 failures;

    t_sent              sent_log[$];
    logic [ADDR_W-1:0]  live_addr[$];
    logic [BYTES_W-1:0] live_bytes[$];
    logic [ADDR_W-1:0]  last_grant;
    bit                 calm;
    bit                 squeeze;
    int                 send_odds;

    segregated_free_list_allocator_top #(
        .HEAP_WORDS   (HEAP_WORDS),
        .SIZE_CLASSES (SIZE_CLASSES),
        .WORD_BYTES   (WORD_BYTES)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_ready           (req_ready),
        .i_req_type        (req_kind),
        .i_request_bytes   (req_bytes),
        .i_block_address   (req_addr),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_granted_address (res_addr),
        .o_status          (res_status),
        .o_from_free_list  (res_reused)
    );

    sfla_checker #(
        .HEAP_WORDS   (HEAP_WORDS),
        .SIZE_CLASSES (SIZE_CLASSES),
        .WORD_BYTES   (WORD_BYTES)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_ready       (req_ready),
        .i_req_type        (req_kind),
        .i_request_bytes   (req_bytes),
        .i_block_address   (req_addr),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_granted_address (res_addr),
        .i_status          (res_status),
        .i_from_free_list  (res_reused),
        .o_failures        (failures)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Granted blocks are remembered so that later frees return real blocks.
    always @(posedge clk) begin : result_tap
        t_sent done;
        if (rst_n && res_valid && res_ready && sent_log.size() != 0) begin
            done       = sent_log.pop_front();
            last_grant = res_addr;
            if (done.kind == REQ_ALLOC && res_status == ST_OK) begin
                live_addr.push_back(res_addr);
                live_bytes.push_back(done.nbytes);
            end
        end
    end

    initial begin : result_sink
        int hold;
        int odds;
        int tick;
        hold      = 0;
        odds      = 0;
        tick      = 0;
        res_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (tick % 64 == 0) begin
                odds = $urandom_range(0, 3);
            end
            tick++;
            if (hold == 0 && !calm) begin
                if (squeeze) begin
                    hold    = SQUEEZE_CYCLES;
                    squeeze = 1'b0;
                end else if (odds != 0 && $urandom_range(0, odds * 4) == 0) begin
                    hold = $urandom_range(1, 14);
                end
            end
            if (hold != 0) begin
                res_ready <= 1'b0;
                hold--;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_word(input t_req op, input logic [BYTES_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] blk);
        int gap;
        gap = 0;
        if (!calm && send_odds != 0 && $urandom_range(0, send_odds * 3) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= op;
        req_bytes <= nbytes;
        req_addr  <= blk;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_log.push_back('{kind: op, nbytes: nbytes});
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (sent_log.size() != 0) @(posedge clk);
    endtask

    task automatic free_block(input logic [ADDR_W-1:0] blk, input logic [BYTES_W-1:0] nbytes);
        int k;
        k = -1;
        foreach (live_addr[i]) begin
            if (k < 0 && live_addr[i] == blk) begin
                k = i;
            end
        end
        if (k >= 0) begin
            live_addr.delete(k);
            live_bytes.delete(k);
        end
        send_word(REQ_FREE, nbytes, blk);
    endtask

    task automatic alloc_now(input logic [BYTES_W-1:0] nbytes, output logic [ADDR_W-1:0] grant);
        send_word(REQ_ALLOC, nbytes, ADDR_W'($urandom));
        settle();
        grant = last_grant;
    endtask

    function automatic logic [BYTES_W-1:0] pick_size();
        int          roll;
        int unsigned words;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            return BYTES_W'($urandom);
        end
        if (roll < 60) begin
            return BYTES_W'($urandom_range(0, 248));
        end
        case ($urandom_range(0, 5))
            0:       words = 32;
            1:       words = 40;
            2:       words = 64;
            3:       words = 128;
            4:       words = 512;
            default: words = 1024;
        endcase
        return BYTES_W'(words * WORD_BYTES - $urandom_range(0, WORD_BYTES - 1));
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0]  a0;
        logic [ADDR_W-1:0]  a1;
        logic [ADDR_W-1:0]  b;
        logic [ADDR_W-1:0]  c;
        logic [ADDR_W-1:0]  d;
        logic [ADDR_W-1:0]  scratch;
        logic [ADDR_W-1:0]  blk;
        logic [BYTES_W-1:0] nbytes;
        logic [ADDR_W-1:0]  echo_addr;
        logic [BYTES_W-1:0] echo_bytes;
        bit                 echo_valid;
        int                 pick;
        int                 k;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_kind   = REQ_ALLOC;
        req_bytes  = '0;
        req_addr   = '0;
        calm       = 1'b0;
        squeeze    = 1'b0;
        send_odds  = 0;
        echo_addr  = '0;
        echo_bytes = '0;
        echo_valid = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero-byte request counts as one word and shares the one-word class.
        alloc_now('0, a0);
        alloc_now(18'd1, a1);
        free_block(a0, '0);
        settle();
        alloc_now(18'd8, scratch);
        free_block('1, 18'd248);
        settle();
        alloc_now(18'd248, scratch);

        // Large blocks: the match sits deep in the shared list, then at its head.
        alloc_now(18'd249, b);
        alloc_now(18'd320, c);
        alloc_now(18'd320, d);
        free_block(b, 18'd256);
        settle();
        free_block(c, 18'd320);
        settle();
        free_block(d, '1);
        settle();
        alloc_now(18'd256, scratch);
        alloc_now('1, scratch);
        alloc_now(18'd320, scratch);
        alloc_now(18'd320, scratch);
        alloc_now(18'd131072, scratch);
        alloc_now('1, scratch);

        // Freeing the same small block twice makes its list point back at itself.
        free_block(a1, 18'd1);
        settle();
        free_block(a1, 18'd1);
        settle();
        alloc_now(18'd1, scratch);
        alloc_now(18'd1, scratch);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0) begin
                send_odds = $urandom_range(0, 3);
            end
            calm = (n >= CALM_FROM);
            if (n == SQUEEZE_AT) begin
                squeeze = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5 && echo_valid && echo_bytes <= 18'd248) begin
                send_word(REQ_FREE, echo_bytes, echo_addr);
            end else if (pick < 45 && live_addr.size() != 0) begin
                k          = $urandom_range(0, live_addr.size() - 1);
                blk        = live_addr[k];
                nbytes     = live_bytes[k];
                echo_addr  = blk;
                echo_bytes = nbytes;
                echo_valid = 1'b1;
                free_block(blk, nbytes);
            end else begin
                send_word(REQ_ALLOC, pick_size(), ADDR_W'($urandom));
            end
        end

        // A large block freed twice loops the shared list, so a miss walks it to the bound.
        settle();
        blk = (live_addr.size() != 0) ? live_addr[0] : '1;
        free_block(blk, 18'd8000);
        send_word(REQ_FREE, 18'd8000, blk);
        send_word(REQ_ALLOC, 18'd8008, ADDR_W'($urandom));
        send_word(REQ_ALLOC, 18'd8000, ADDR_W'($urandom));
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
